// ===== sv/absr_pkg.sv =====
// Shared types, constants and the palette function for the scanline renderer.
package absr_pkg;

    // Default frame geometry
    localparam int DEF_TOTAL_LINES       = 240;
    localparam int DEF_TOP_BORDER        = 24;
    localparam int DEF_SIDE_BORDER_PAIRS = 16;

    // Video memory split into a bitmap part and an attribute part
    localparam int BITMAP_DEPTH = 6144;
    localparam int ATTR_DEPTH   = 768;
    localparam int MEM_SIZE     = 6912;
    localparam int CELLS        = 32;
    localparam int ACTIVE_LINES = 192;
    localparam int BITMAP_AW    = 13;
    localparam int ATTR_AW      = 10;

    // Function codes of an input word
    localparam logic FUNC_WRITE  = 1'b0;
    localparam logic FUNC_RENDER = 1'b1;

    typedef enum logic {
        ST_IDLE,
        ST_RUN
    } t_state;

    // Controller to datapath commands
    typedef struct packed {
        logic       write;   // store one memory byte
        logic       load;    // latch a render word
        logic       issue;   // one result slot enters the pipe
        logic       border;  // slot shows border colour
        logic       last;    // slot is the last of the line
        logic [4:0] col;     // character column of the slot
    } t_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic active;        // latched line lies in the picture area
    } t_status;

    // Palette index to RGB444: bit 0 blue, bit 1 red, bit 2 green, bit 3 bright
    function automatic logic [11:0] palette(input logic [3:0] idx);
        logic [3:0] lvl;
        lvl = idx[3] ? 4'hF : 4'h8;
        return {idx[1] ? lvl : 4'h0, idx[2] ? lvl : 4'h0, idx[0] ? lvl : 4'h0};
    endfunction

endpackage

// ===== sv/absr_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module absr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== sv/absr_ctrl.sv =====
// Controller: accepts words and sequences the result slots of a line.
module absr_ctrl #(
    parameter int SIDE_BORDER_PAIRS = absr_pkg::DEF_SIDE_BORDER_PAIRS
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             start,
    input  logic             i_func,
    input  absr_pkg::t_status i_status,
    output absr_pkg::t_cmd   o_cmd,
    output logic             busy
);
    import absr_pkg::*;

    localparam int SIDE_CELLS = (SIDE_BORDER_PAIRS / 4 > 4) ? 4 : SIDE_BORDER_PAIRS / 4;
    localparam int TOTAL      = 2 * SIDE_CELLS + CELLS;
    localparam logic [5:0] SIDE_L  = 6'(SIDE_CELLS);
    localparam logic [5:0] RIGHT_L = 6'(SIDE_CELLS + CELLS);
    localparam logic [5:0] LAST_L  = 6'(TOTAL - 1);

    t_state     r_state, n_state;
    logic [5:0] r_slot, n_slot;
    logic       w_accept;
    logic [5:0] w_cell_full;

    assign w_accept    = start && (r_state == ST_IDLE);
    assign w_cell_full = r_slot - SIDE_L;

    // State and slot counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_slot  <= '0;
        end else begin
            r_state <= n_state;
            r_slot  <= n_slot;
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        n_slot  = r_slot;
        case (r_state)
            ST_IDLE: begin
                n_slot = '0;
                if (w_accept && i_func == FUNC_RENDER) begin
                    n_state = ST_RUN;
                end
            end
            ST_RUN: begin
                n_slot = r_slot + 6'd1;
                if (r_slot == LAST_L) begin
                    n_state = ST_IDLE;
                    n_slot  = '0;
                end
            end
            default: begin
                n_state = ST_IDLE;
                n_slot  = '0;
            end
        endcase
    end

    // Outputs
    always_comb begin
        o_cmd = '0;
        busy  = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_cmd.write = w_accept && i_func == FUNC_WRITE;
                o_cmd.load  = w_accept && i_func == FUNC_RENDER;
            end
            ST_RUN: begin
                busy         = 1'b1;
                o_cmd.issue  = 1'b1;
                o_cmd.border = !i_status.active || r_slot < SIDE_L || r_slot >= RIGHT_L;
                o_cmd.last   = r_slot == LAST_L;
                o_cmd.col    = w_cell_full[4:0];
            end
            default: begin
                busy = 1'b0;
            end
        endcase
    end

endmodule

// ===== sv/absr_datapath.sv =====
// Datapath: video memory, address generation, colour decode and result register.
module absr_datapath #(
    parameter int TOTAL_LINES = absr_pkg::DEF_TOTAL_LINES,
    parameter int TOP_BORDER  = absr_pkg::DEF_TOP_BORDER
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  absr_pkg::t_cmd    i_cmd,
    input  logic [12:0]       i_mem_address,
    input  logic [7:0]        i_mem_data,
    input  logic [7:0]        i_line_number,
    input  logic [7:0]        i_frame_count,
    input  logic [3:0]        i_border_colour,
    output absr_pkg::t_status o_status,
    output logic              o_strobe,
    output logic [23:0]       o_pair_a,
    output logic [23:0]       o_pair_b,
    output logic [23:0]       o_pair_c,
    output logic [23:0]       o_pair_d,
    output logic              o_end_of_line
);
    import absr_pkg::*;

    localparam logic [9:0]  TOT_L   = 10'(TOTAL_LINES);
    localparam logic [9:0]  TOP_L   = 10'(TOP_BORDER);
    localparam logic [9:0]  END_L   = 10'(TOP_BORDER + ACTIVE_LINES);
    localparam logic [7:0]  TOP_B   = 8'(TOP_BORDER);
    localparam logic [12:0] ATTR_B  = 13'(BITMAP_DEPTH);
    localparam logic [12:0] MEM_END = 13'(MEM_SIZE);

    // Latched render word
    logic        r_active;
    logic [7:0]  r_vrow;
    logic        r_flash;
    logic [11:0] r_bpal;

    // Slot pipe stage matching the memory read latency
    logic        r_s1_valid;
    logic        r_s1_border;
    logic        r_s1_last;

    // Result register
    logic        r_o_valid;
    logic [23:0] r_pair [4];
    logic        r_eol;

    logic [9:0]          w_line;
    logic [12:0]         w_attr_off;
    logic                w_bm_we;
    logic                w_at_we;
    logic [BITMAP_AW-1:0] w_bm_raddr;
    logic [ATTR_AW-1:0]   w_at_raddr;
    logic [7:0]          w_bm_data;
    logic [7:0]          w_at_data;
    logic [7:0]          w_pix;
    logic [11:0]         w_ink;
    logic [11:0]         w_paper;
    logic [23:0]         w_pair [4];

    // Write decode: below the attribute base is bitmap, past the end is dropped
    assign w_attr_off = i_mem_address - ATTR_B;
    assign w_bm_we    = i_cmd.write && i_mem_address < ATTR_B;
    assign w_at_we    = i_cmd.write && i_mem_address >= ATTR_B && i_mem_address < MEM_END;

    // Interleaved bitmap address: third, pixel row, character row
    assign w_bm_raddr = {r_vrow[7:6], r_vrow[2:0], r_vrow[5:3], i_cmd.col};
    assign w_at_raddr = {r_vrow[7:3], i_cmd.col};

    absr_ram #(
        .WIDTH(8),
        .DEPTH(BITMAP_DEPTH)
    ) u_bitmap (
        .i_clk  (i_clk),
        .i_we   (w_bm_we),
        .i_waddr(i_mem_address),
        .i_wdata(i_mem_data),
        .i_raddr(w_bm_raddr),
        .o_rdata(w_bm_data)
    );

    absr_ram #(
        .WIDTH(8),
        .DEPTH(ATTR_DEPTH)
    ) u_attr (
        .i_clk  (i_clk),
        .i_we   (w_at_we),
        .i_waddr(w_attr_off[ATTR_AW-1:0]),
        .i_wdata(i_mem_data),
        .i_raddr(w_at_raddr),
        .o_rdata(w_at_data)
    );

    // Render word latch
    assign w_line = {2'b00, i_line_number};
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_active <= w_line < TOT_L && w_line >= TOP_L && w_line < END_L;
            r_vrow   <= i_line_number - TOP_B;
            r_flash  <= i_frame_count[5];
            r_bpal   <= palette(i_border_colour);
        end
    end

    assign o_status.active = r_active;

    // Slot pipe control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_o_valid  <= 1'b0;
        end else begin
            r_s1_valid <= i_cmd.issue;
            r_o_valid  <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_border <= i_cmd.border;
        r_s1_last   <= i_cmd.last;
    end

    // Colour decode: bright applies to ink and paper, flash inverts the byte
    assign w_pix   = (w_at_data[7] && r_flash) ? ~w_bm_data : w_bm_data;
    assign w_ink   = palette({w_at_data[6], w_at_data[2:0]});
    assign w_paper = palette(w_at_data[6:3]);

    always_comb begin
        for (int j = 0; j < 4; j++) begin
            if (r_s1_border) begin
                w_pair[j] = {r_bpal, r_bpal};
            end else begin
                w_pair[j] = {w_pix[7 - 2 * j] ? w_ink : w_paper,
                             w_pix[6 - 2 * j] ? w_ink : w_paper};
            end
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        for (int j = 0; j < 4; j++) begin
            r_pair[j] <= w_pair[j];
        end
        r_eol <= r_s1_last;
    end

    assign o_strobe      = r_o_valid;
    assign o_pair_a      = r_pair[0];
    assign o_pair_b      = r_pair[1];
    assign o_pair_c      = r_pair[2];
    assign o_pair_d      = r_pair[3];
    assign o_end_of_line = r_eol;

endmodule

// ===== sv/attribute_bitmap_scanline_render_top.sv =====
// Top level of the attribute-colour bitmap scanline renderer.
//
//  channel  | handshake               | payload
//  ---------+-------------------------+----------------------------------------------
//  input    | start, busy             | i_func, i_mem_address, i_mem_data,
//           |                         | i_line_number, i_frame_count, i_border_colour
//  result   | o_strobe (one cycle)    | o_pair_a..o_pair_d, o_end_of_line
//
// A write word leaves busy low. A render word holds busy while its 2*side+32
// slots (40 by default) are issued, one slot per cycle, since bitmap and
// attributes sit in two memories that are both read once per cell. Results
// leave via the slot pipe stage and the result register; the next word can be
// taken while the tail of a line is still in flight. Reset is synchronous and
// active low; the video memory is not cleared. The receiver cannot stall results.
module attribute_bitmap_scanline_render_top #(
    parameter int TOTAL_LINES       = absr_pkg::DEF_TOTAL_LINES,
    parameter int TOP_BORDER        = absr_pkg::DEF_TOP_BORDER,
    parameter int SIDE_BORDER_PAIRS = absr_pkg::DEF_SIDE_BORDER_PAIRS
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        i_func,
    input  logic [12:0] i_mem_address,
    input  logic [7:0]  i_mem_data,
    input  logic [7:0]  i_line_number,
    input  logic [7:0]  i_frame_count,
    input  logic [3:0]  i_border_colour,
    output logic        o_strobe,
    output logic [23:0] o_pair_a,
    output logic [23:0] o_pair_b,
    output logic [23:0] o_pair_c,
    output logic [23:0] o_pair_d,
    output logic        o_end_of_line
);
    import absr_pkg::*;

    t_cmd    w_cmd;
    t_status w_status;

    absr_ctrl #(
        .SIDE_BORDER_PAIRS(SIDE_BORDER_PAIRS)
    ) u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .i_func  (i_func),
        .i_status(w_status),
        .o_cmd   (w_cmd),
        .busy    (busy)
    );

    absr_datapath #(
        .TOTAL_LINES(TOTAL_LINES),
        .TOP_BORDER (TOP_BORDER)
    ) u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (w_cmd),
        .i_mem_address  (i_mem_address),
        .i_mem_data     (i_mem_data),
        .i_line_number  (i_line_number),
        .i_frame_count  (i_frame_count),
        .i_border_colour(i_border_colour),
        .o_status       (w_status),
        .o_strobe       (o_strobe),
        .o_pair_a       (o_pair_a),
        .o_pair_b       (o_pair_b),
        .o_pair_c       (o_pair_c),
        .o_pair_d       (o_pair_d),
        .o_end_of_line  (o_end_of_line)
    );

endmodule

// ===== bench/tb.sv =====
// Self-checking testbench for the attribute-colour bitmap scanline renderer.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import absr_pkg::*;

    localparam int TOTAL_LINES       = 240;
    localparam int TOP_BORDER        = 24;
    localparam int SIDE_BORDER_PAIRS = 16;
    localparam int SIDE_COLUMNS      = (SIDE_BORDER_PAIRS / 4 > 4) ? 4 : SIDE_BORDER_PAIRS / 4;
    localparam int LINE_WORDS        = 2 * SIDE_COLUMNS + CELLS;
    localparam int DRAIN_CYCLES      = 8;
    localparam int CYCLE_LIMIT       = 400000;
    localparam int ADDR_SPAN         = 8192;
    localparam int FILLED_ROWS       = 4;

    // One result word: four pixel pairs and the end-of-line flag
    typedef struct packed {
        logic [23:0] pa;
        logic [23:0] pb;
        logic [23:0] pc;
        logic [23:0] pd;
        logic        eol;
    } t_pixel_word;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        start;
    logic        busy;
    logic        i_func;
    logic [12:0] i_mem_address;
    logic [7:0]  i_mem_data;
    logic [7:0]  i_line_number;
    logic [7:0]  i_frame_count;
    logic [3:0]  i_border_colour;
    logic        o_strobe;
    logic [23:0] o_pair_a;
    logic [23:0] o_pair_b;
    logic [23:0] o_pair_c;
    logic [23:0] o_pair_d;
    logic        o_end_of_line;

    // Shadow video memory and the words still owed by the block
    logic [7:0]  video_bytes [MEM_SIZE];
    t_pixel_word pending_words [$];

    int    errors         = 0;
    int    words_checked  = 0;
    int    bytes_written  = 0;
    int    writes_dropped = 0;
    int    active_renders = 0;
    int    border_renders = 0;
    int    cycle_count    = 0;
    bit    sender_idles   = 1'b1;

    attribute_bitmap_scanline_render_top #(
        .TOTAL_LINES      (TOTAL_LINES),
        .TOP_BORDER       (TOP_BORDER),
        .SIDE_BORDER_PAIRS(SIDE_BORDER_PAIRS)
    ) i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_func         (i_func),
        .i_mem_address  (i_mem_address),
        .i_mem_data     (i_mem_data),
        .i_line_number  (i_line_number),
        .i_frame_count  (i_frame_count),
        .i_border_colour(i_border_colour),
        .o_strobe       (o_strobe),
        .o_pair_a       (o_pair_a),
        .o_pair_b       (o_pair_b),
        .o_pair_c       (o_pair_c),
        .o_pair_d       (o_pair_d),
        .o_end_of_line  (o_end_of_line)
    );

    always #5ns i_clk = ~i_clk;

    // Hard stop in case the block hangs
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d words outstanding", cycle_count,
                     pending_words.size());
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // Palette index to RGB444: bit 0 blue, bit 1 red, bit 2 green, bit 3 bright
    function automatic logic [11:0] rgb_of(input logic [3:0] idx);
        logic [3:0] level;
        level = idx[3] ? 4'hF : 4'h8;
        return {idx[1] ? level : 4'h0, idx[2] ? level : 4'h0, idx[0] ? level : 4'h0};
    endfunction

    // Picture rows whose bitmap and attribute bytes are all written
    function automatic int picture_row(input int k);
        case (k)
            0:       return 0;
            1:       return 7;
            2:       return 72;
            default: return ACTIVE_LINES - 1;
        endcase
    endfunction

    // Interleaved bitmap order: third, pixel row, character row
    function automatic int bitmap_base(input int v);
        return ((v & 'h7) << 8) + ((v & 'h38) << 2) + ((v & 'hC0) << 5);
    endfunction

    function automatic int attr_row_base(input int v);
        return BITMAP_DEPTH + ((v >> 3) << 5);
    endfunction

    // Expected words of one rendered line, in display order
    task automatic predict_line(input logic [7:0] line, input logic [7:0] frame,
                                input logic [3:0] bcol);
        logic [11:0] border_rgb;
        logic [11:0] ink_rgb;
        logic [11:0] paper_rgb;
        logic [23:0] border_pair;
        logic [23:0] pr [4];
        logic [7:0]  attr;
        logic [7:0]  bits;
        logic [1:0]  two;
        t_pixel_word w;
        int          v;
        int          bmp_base;
        int          attr_base;
        border_rgb  = rgb_of(bcol);
        border_pair = {border_rgb, border_rgb};
        if (line >= TOTAL_LINES || line < TOP_BORDER || line >= TOP_BORDER + ACTIVE_LINES) begin
            border_renders++;
            for (int i = 0; i < LINE_WORDS; i++) begin
                w = '{border_pair, border_pair, border_pair, border_pair, i == LINE_WORDS - 1};
                pending_words.push_back(w);
            end
            return;
        end
        active_renders++;
        v = line - TOP_BORDER;
        bmp_base  = bitmap_base(v);
        attr_base = attr_row_base(v);
        for (int i = 0; i < SIDE_COLUMNS; i++) begin
            w = '{border_pair, border_pair, border_pair, border_pair, 1'b0};
            pending_words.push_back(w);
        end
        for (int i = 0; i < CELLS; i++) begin
            attr      = video_bytes[attr_base + i];
            bits      = video_bytes[bmp_base + i];
            paper_rgb = rgb_of(attr[6:3]);
            ink_rgb   = rgb_of({attr[6], attr[2:0]});
            // Flash inverts the bitmap in the second half of the flash period
            if (attr[7] && frame[5])
                bits = ~bits;
            for (int j = 0; j < 4; j++) begin
                two   = bits[7 - 2 * j -: 2];
                pr[j] = {two[1] ? ink_rgb : paper_rgb, two[0] ? ink_rgb : paper_rgb};
            end
            w = '{pr[0], pr[1], pr[2], pr[3], SIDE_COLUMNS == 0 && i == CELLS - 1};
            pending_words.push_back(w);
        end
        for (int i = 0; i < SIDE_COLUMNS; i++) begin
            w = '{border_pair, border_pair, border_pair, border_pair, i == SIDE_COLUMNS - 1};
            pending_words.push_back(w);
        end
    endtask

    // Drive one word, hold it until taken, then update the prediction
    task automatic issue_word(input logic func, input logic [12:0] addr, input logic [7:0] data,
                              input logic [7:0] line, input logic [7:0] frame,
                              input logic [3:0] bcol);
        i_func          <= func;
        i_mem_address   <= addr;
        i_mem_data      <= data;
        i_line_number   <= line;
        i_frame_count   <= frame;
        i_border_colour <= bcol;
        start           <= 1'b1;
        @(posedge i_clk);
        while (busy !== 1'b0)
            @(posedge i_clk);
        if (func == FUNC_WRITE) begin
            if (addr < MEM_SIZE) begin
                video_bytes[addr] = data;
                bytes_written++;
            end else begin
                writes_dropped++;
            end
        end else begin
            predict_line(line, frame, bcol);
        end
    endtask

    // Random sender pause
    task automatic sender_gap();
        if (sender_idles && $urandom_range(0, 3) == 0) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge i_clk);
        end
    endtask

    task automatic write_byte(input logic [12:0] addr, input logic [7:0] data);
        issue_word(FUNC_WRITE, addr, data, 8'($urandom), 8'($urandom), 4'($urandom));
        sender_gap();
    endtask

    task automatic render_line(input logic [7:0] line, input logic [7:0] frame,
                               input logic [3:0] bcol);
        issue_word(FUNC_RENDER, 13'($urandom), 8'($urandom), line, frame, bcol);
        sender_gap();
    endtask

    task automatic wait_for_results();
        start <= 1'b0;
        @(posedge i_clk);
        while (pending_words.size() != 0)
            @(posedge i_clk);
    endtask

    task automatic report_mismatch(input string field, input logic [23:0] got,
                                   input logic [23:0] want);
        $display("mismatch on word %0d, %s: got %h, want %h", words_checked, field, got, want);
        errors++;
    endtask

    // Every strobed word is compared with the oldest prediction
    always @(posedge i_clk) begin : check_words
        t_pixel_word want;
        if (i_rst_n === 1'b1 && o_strobe !== 1'b0) begin
            if (o_strobe !== 1'b1) begin
                report_mismatch("strobe", 24'(o_strobe), 24'd1);
            end else if (pending_words.size() == 0) begin
                report_mismatch("unexpected word", o_pair_a, 24'h0);
            end else begin
                want = pending_words.pop_front();
                if (o_pair_a !== want.pa) report_mismatch("pair_a", o_pair_a, want.pa);
                if (o_pair_b !== want.pb) report_mismatch("pair_b", o_pair_b, want.pb);
                if (o_pair_c !== want.pc) report_mismatch("pair_c", o_pair_c, want.pc);
                if (o_pair_d !== want.pd) report_mismatch("pair_d", o_pair_d, want.pd);
                if (o_end_of_line !== want.eol)
                    report_mismatch("end_of_line", 24'(o_end_of_line), 24'(want.eol));
                words_checked++;
            end
        end
    end

    // Border lines need no memory: top, bottom, last and out-of-range lines
    task automatic test_border_lines();
        render_line(8'd0, 8'h00, 4'h0);
        render_line(8'(TOP_BORDER - 1), 8'hFF, 4'hF);
        render_line(8'(TOP_BORDER + ACTIVE_LINES), 8'h20, 4'h7);
        render_line(8'(TOTAL_LINES - 1), 8'hDF, 4'h8);
        render_line(8'd255, 8'h5A, 4'hA);
    endtask

    // Fill bitmap and attributes of a few picture rows; active renders use only these
    task automatic test_memory_fill();
        int v;
        for (int k = 0; k < FILLED_ROWS; k++) begin
            v = picture_row(k);
            for (int i = 0; i < CELLS; i++)
                write_byte(13'(bitmap_base(v) + i), 8'($urandom));
            // rows in one character row share their attributes
            if (k == 0 || (v >> 3) != (picture_row(k - 1) >> 3)) begin
                for (int i = 0; i < CELLS; i++)
                    write_byte(13'(attr_row_base(v) + i), 8'($urandom));
            end
        end
    endtask

    // First active line: ink/paper, bright and flash combinations
    task automatic test_cell_colours();
        logic [7:0] attrs [8] = '{8'h00, 8'hFF, 8'h47, 8'h38, 8'h85, 8'hC2, 8'h7A, 8'h01};
        logic [7:0] bmps  [8] = '{8'hFF, 8'h00, 8'hAA, 8'h55, 8'h81, 8'h0F, 8'hF0, 8'h3C};
        for (int i = 0; i < 8; i++) begin
            write_byte(13'(BITMAP_DEPTH + i), attrs[i]);
            write_byte(13'(i), bmps[i]);
        end
        render_line(8'(TOP_BORDER), 8'h20, 4'h3);
        render_line(8'(TOP_BORDER), 8'hDF, 4'hC);
        // hold off until the block has delivered everything
        wait_for_results();
    endtask

    // Interleaved addressing across character rows and thirds
    task automatic test_line_addressing();
        render_line(8'(TOP_BORDER + ACTIVE_LINES - 1), 8'h00, 4'h1);
        render_line(8'(TOP_BORDER + 7), 8'h3F, 4'h9);
        render_line(8'(TOP_BORDER + 8 + 64), 8'hE0, 4'h6);
    endtask

    // Writes past the end of memory are dropped
    task automatic test_dropped_writes();
        write_byte(13'(MEM_SIZE), 8'hA5);
        write_byte(13'(ADDR_SPAN - 1), 8'h5A);
        render_line(8'(TOP_BORDER), 8'h20, 4'h2);
    endtask

    // Mixed writes and renders with random content
    task automatic test_random_traffic(input int count);
        logic [12:0] addr;
        logic [7:0]  line;
        int          v;
        for (int n = 0; n < count; n++) begin
            if ($urandom_range(0, 99) < 35) begin
                v = picture_row($urandom_range(0, FILLED_ROWS - 1));
                case ($urandom_range(0, 5))
                    0:       addr = 13'($urandom_range(MEM_SIZE, ADDR_SPAN - 1));
                    1:       addr = 13'($urandom_range(0, MEM_SIZE - 1));
                    2:       addr = 13'(attr_row_base(v) + $urandom_range(0, CELLS - 1));
                    default: addr = 13'(bitmap_base(v) + $urandom_range(0, CELLS - 1));
                endcase
                write_byte(addr, 8'($urandom));
            end else begin
                case ($urandom_range(0, 5))
                    0:       line = 8'($urandom_range(0, TOP_BORDER - 1));
                    1:       line = 8'($urandom_range(TOP_BORDER + ACTIVE_LINES, 255));
                    default: line = 8'(TOP_BORDER +
                                       picture_row($urandom_range(0, FILLED_ROWS - 1)));
                endcase
                render_line(line, 8'($urandom), 4'($urandom));
            end
        end
    endtask

    initial begin
        i_rst_n         <= 1'b0;
        start           <= 1'b0;
        i_func          <= FUNC_WRITE;
        i_mem_address   <= '0;
        i_mem_data      <= '0;
        i_line_number   <= '0;
        i_frame_count   <= '0;
        i_border_colour <= '0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_border_lines();
        test_memory_fill();
        test_cell_colours();
        test_line_addressing();
        test_dropped_writes();
        test_random_traffic(55);
        // back-to-back words to close the run
        sender_idles = 1'b0;
        test_random_traffic(25);

        wait_for_results();
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("covered %0d byte writes (%0d dropped), %0d active and %0d border lines",
                 bytes_written, writes_dropped, active_renders, border_renders);
        $display("checked %0d pixel words in %0d cycles, %0d mismatches",
                 words_checked, cycle_count, errors);
        if (errors == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
